FILE: src/adc_pkg.sv
// shared types and constants for the axis deadzone conditioner
package adc_pkg;

  localparam int unsigned OUT_W      = 24;
  localparam int unsigned DZ_W       = 15;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DEN_W      = 17;
  localparam int unsigned QUOT_W     = 24;
  localparam int unsigned PROD_SHIFT = 7;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = QUOT_W / DIV_STEPS;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int ONE_Q16  = 65536;
  localparam int HALF_Q16 = 32768;

  localparam logic [OUT_W-1:0]  OUT_MAX   = 24'h7F_FFFF;
  localparam logic [OUT_W-1:0]  OUT_MIN   = 24'h80_0000;
  localparam logic [GAIN_W-1:0] GAIN_UNIT = 16'd256;

  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DZ     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 4'd3;

  typedef enum logic [1:0] {
    RANGE_FULL = 2'd0,
    RANGE_FWD  = 2'd1,
    RANGE_BWD  = 2'd2
  } range_mode_e;

  typedef struct packed {
    logic neg;
    logic ovf;
  } div_tag_t;

endpackage

FILE: src/adc_if.sv
// beat interfaces for sample input, result output and register writes
interface adc_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface adc_result_if import adc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] conditioned_value;

  modport source (output valid, output conditioned_value, input ready);
  modport sink   (input valid, input conditioned_value, output ready);
endinterface

interface adc_cfg_if import adc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: src/adc_div.sv
// pipelined restoring divider with saturation tag passed alongside
module adc_div import adc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DEN_W-1:0]  in_rem_i,
  input  logic [QUOT_W-1:0] in_dq_i,
  input  logic [DEN_W-1:0]  in_den_i,
  input  div_tag_t          in_tag_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [QUOT_W-1:0] out_quot_o,
  output div_tag_t          out_tag_o
);

  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [QUOT_W-1:0] dq;
  } div_acc_t;

  function automatic div_acc_t div_steps(div_acc_t acc, logic [DEN_W-1:0] den);
    logic [DEN_W:0] trial;
    div_acc_t       a;
    a = acc;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial = {a.rem, a.dq[QUOT_W-1]};
      if (trial >= {1'b0, den}) begin
        a.rem = DEN_W'(trial - {1'b0, den});
        a.dq  = {a.dq[QUOT_W-2:0], 1'b1};
      end else begin
        a.rem = trial[DEN_W-1:0];
        a.dq  = {a.dq[QUOT_W-2:0], 1'b0};
      end
    end
    return a;
  endfunction

  logic [DIV_STAGES-1:0] vld_q;
  logic [DIV_STAGES-1:0] en;
  div_acc_t              acc_q [DIV_STAGES];
  div_acc_t              acc_d [DIV_STAGES];
  logic [DEN_W-1:0]      den_q [DIV_STAGES];
  div_tag_t              tag_q [DIV_STAGES];

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[DIV_STAGES-1] = !vld_q[DIV_STAGES-1] || out_ready_i;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    acc_d[0] = div_steps(div_acc_t'{rem: in_rem_i, dq: in_dq_i}, in_den_i);
    for (int k = 1; k < DIV_STAGES; k++) begin
      acc_d[k] = div_steps(acc_q[k-1], den_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      acc_q[0] <= acc_d[0];
      den_q[0] <= in_den_i;
      tag_q[0] <= in_tag_i;
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        acc_q[k] <= acc_d[k];
        den_q[k] <= den_q[k-1];
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[DIV_STAGES-1];
  assign out_quot_o  = acc_q[DIV_STAGES-1].dq;
  assign out_tag_o   = tag_q[DIV_STAGES-1];

endmodule

FILE: src/axis_deadzone_conditioner_top.sv
// axis deadzone conditioner top level: config registers, datapath pipeline
//
//   port      dir   beat payload         notes
//   sample_i  in    raw_sample           signed, SAMPLE_WIDTH bits
//   result_o  out   conditioned_value    signed Q9.15, ratio times gain, 24 bits
//   cfg_i     in    reg_index, wdata     always ready, unknown index dropped
//
// one sample per cycle while the output is not stalled; four front stages, six
// divider stages of four quotient bits each, one output register
// reset clears all valid bits and loads the register reset values
// each stage advances when it is empty or its successor advances, so
// bubbles close up under a stalled output and nothing is lost or repeated
module axis_deadzone_conditioner_top import adc_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  adc_sample_if.sink  sample_i,
  adc_result_if.source result_o,
  adc_cfg_if.sink     cfg_i
);

  localparam int unsigned MW = (SAMPLE_WIDTH + 1 > DEN_W) ? SAMPLE_WIDTH + 1 : DEN_W;
  localparam int unsigned VW = MW + 1;
  localparam int unsigned PW = MW + GAIN_W;
  localparam int unsigned LOW_W = QUOT_W - PROD_SHIFT;

  // configuration registers
  logic              invert_q;
  range_mode_e       range_q;
  logic [DZ_W-1:0]   dz_q;
  logic [GAIN_W-1:0] gain_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
      range_q  <= RANGE_FULL;
      dz_q     <= '0;
      gain_q   <= GAIN_UNIT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_INVERT: invert_q <= cfg_i.wdata[0];
        CFG_RANGE:  range_q  <= range_mode_e'(cfg_i.wdata[1:0]);
        CFG_DZ:     dz_q     <= cfg_i.wdata[DZ_W-1:0];
        CFG_GAIN:   gain_q   <= cfg_i.wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables
  logic out_vld_q, div_out_vld, div_in_rdy;
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic en_out, en4, en3, en2, en1;

  assign en_out = !out_vld_q || result_o.ready;
  assign en4    = !s4_vld_q || div_in_rdy;
  assign en3    = !s3_vld_q || en4;
  assign en2    = !s2_vld_q || en3;
  assign en1    = !s1_vld_q || en2;

  assign sample_i.ready = en1;

  // stage 1: invert and range mapping into 2^-16 units
  logic signed [VW-1:0] v_sx, v_inv, v16_d, v16_q;

  always_comb begin
    v_sx  = VW'(sample_i.raw_sample);
    v_inv = invert_q ? -v_sx : v_sx;
    unique case (range_q)
      RANGE_FWD: v16_d = v_inv + VW'(HALF_Q16);
      RANGE_BWD: v16_d = v_inv - VW'(HALF_Q16);
      default:   v16_d = v_inv <<< 1;
    endcase
  end

  // stage 2: magnitude less deadzone
  logic          neg_d, s2_neg_q;
  logic [VW-1:0] abs_v;
  logic [MW-1:0] mag, dz16, num_d, num_q;

  always_comb begin
    neg_d = v16_q[VW-1];
    abs_v = neg_d ? VW'(-v16_q) : VW'(v16_q);
    mag   = abs_v[MW-1:0];
    dz16  = MW'({dz_q, 1'b0});
    num_d = (mag > dz16) ? (mag - dz16) : '0;
  end

  // stage 3: gain product
  logic          s3_neg_q;
  logic [PW-1:0] prod_d, prod_q;

  assign prod_d = PW'(num_q) * PW'(gain_q);

  // stage 4: overflow check and divider setup
  logic [PW-LOW_W-1:0] hi;
  logic [DEN_W-1:0]    den_d, den_q, rem_d, rem_q;
  logic [QUOT_W-1:0]   lo_d, lo_q;
  div_tag_t            tag_d, tag_q;

  always_comb begin
    hi        = prod_q[PW-1:LOW_W];
    den_d     = DEN_W'(ONE_Q16) - DEN_W'({dz_q, 1'b0});
    tag_d.neg = s3_neg_q;
    tag_d.ovf = MW'(hi) >= MW'(den_d);
    rem_d     = tag_d.ovf ? '0 : DEN_W'(hi);
    lo_d      = {prod_q[LOW_W-1:0], {PROD_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (en1) s1_vld_q <= sample_i.valid;
      if (en2) s2_vld_q <= s1_vld_q;
      if (en3) s3_vld_q <= s2_vld_q;
      if (en4) s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) v16_q <= v16_d;
    if (en2) begin
      num_q    <= num_d;
      s2_neg_q <= neg_d;
    end
    if (en3) begin
      prod_q   <= prod_d;
      s3_neg_q <= s2_neg_q;
    end
    if (en4) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
      den_q <= den_d;
      tag_q <= tag_d;
    end
  end

  logic [QUOT_W-1:0] quot;
  div_tag_t          quot_tag;

  adc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s4_vld_q),
    .in_ready_o  (div_in_rdy),
    .in_rem_i    (rem_q),
    .in_dq_i     (lo_q),
    .in_den_i    (den_q),
    .in_tag_i    (tag_q),
    .out_valid_o (div_out_vld),
    .out_ready_i (en_out),
    .out_quot_o  (quot),
    .out_tag_o   (quot_tag)
  );

  // output: saturate and apply sign
  logic [OUT_W-1:0] res_d, res_q;

  always_comb begin
    if (quot_tag.neg) begin
      if (quot_tag.ovf || (quot > QUOT_W'(OUT_MIN))) res_d = OUT_MIN;
      else                                          res_d = OUT_W'(-quot);
    end else begin
      if (quot_tag.ovf || (quot > QUOT_W'(OUT_MAX))) res_d = OUT_MAX;
      else                                          res_d = OUT_W'(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_out) begin
      out_vld_q <= div_out_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) res_q <= res_d;
  end

  assign result_o.valid             = out_vld_q;
  assign result_o.conditioned_value = res_q;

endmodule
